// ----- rtl/btsb_pkg.sv -----
// Shared types and constants for the byte trigram set builder.
// Used by the front end, back end and top level; depends on nothing.
`default_nettype none

package btsb_pkg;

   // Field widths
   localparam int GRAM_BITS  = 24;
   localparam int COUNT_BITS = 25;
   localparam int BYTE_BITS  = 8;

   // Default configuration and structure sizes
   localparam logic [COUNT_BITS-1:0] LIMIT_RESET = 25'd20000;
   localparam int WINDOW_BYTES_DEFAULT = 3;
   localparam int QUEUE_DEPTH_DEFAULT  = 4;
   localparam int OUT_DEPTH_DEFAULT    = 4;

   // Seen map layout: 64-bit rows tagged with a file epoch
   localparam int ROW_SEL_BITS  = 6;
   localparam int ROW_BITS      = 1 << ROW_SEL_BITS;
   localparam int ROW_ADDR_BITS = GRAM_BITS - ROW_SEL_BITS;
   localparam int MAP_ROWS      = 1 << ROW_ADDR_BITS;
   localparam int EPOCH_BITS    = 8;
   localparam int ENTRY_BITS    = ROW_BITS + EPOCH_BITS;
   localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = 8'd1;
   localparam logic [EPOCH_BITS-1:0] EPOCH_MAX   = 8'hFF;

   // Register port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_INDEX_MAX_DISTINCT = 1'b0;

   // Classified request from the front to the back
   typedef struct packed {
      logic [GRAM_BITS-1:0] gram;
      logic                 gram_valid;
      logic                 last;
   } item_type;

   // Finished result on its way to the response channel
   typedef struct packed {
      logic [GRAM_BITS-1:0] trigram;
      logic                 trigram_valid;
      logic                 is_new;
      logic                 overflowed;
      logic                 file_done;
   } result_type;

   // Back end status seen by the top level
   typedef struct packed {
      logic clearing;
      logic pop;
      logic busy;
   } back_status_type;

endpackage

`default_nettype wire

// ----- rtl/btsb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`default_nettype none

module btsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/btsb_fifo.sv -----
// Small generic request queue in flip-flops, used between the front and back
// and in front of the response channel. No dependencies.
`default_nettype none

module btsb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   input  wire logic                       pop,
   output logic      [WIDTH-1:0]           pop_data,
   output logic                            empty,
   output logic                            full,
   output logic      [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    entries_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                do_push;
   logic                do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_FULL);
   assign count   = count_ff;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // Store the incoming request
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!do_push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/btsb_front.sv -----
// Front end: keeps the sliding byte window and classifies each request into
// a gram with a valid mark. Depends on btsb_pkg.
`default_nettype none

module btsb_front #(
   parameter int WINDOW_BYTES = btsb_pkg::WINDOW_BYTES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   input  wire logic [btsb_pkg::BYTE_BITS-1:0]  byte_value,
   input  wire logic                            last_byte,
   output btsb_pkg::item_type                   item
);

   localparam int HIST_BITS = btsb_pkg::BYTE_BITS * (WINDOW_BYTES - 1);
   localparam int WIDE_BITS = btsb_pkg::BYTE_BITS * WINDOW_BYTES;
   localparam logic [1:0] FILL_FULL = 2'(WINDOW_BYTES - 1);

   logic [HIST_BITS-1:0] hist_ff;
   logic [HIST_BITS-1:0] hist_in;
   logic [1:0]           fill_ff;
   logic [1:0]           fill_in;
   logic [WIDE_BITS-1:0] wide;
   logic                 full;

   assign wide = {hist_ff, byte_value};
   assign full = (fill_ff >= FILL_FULL);

   // Classify the request
   always_comb begin
      item.gram       = full ? btsb_pkg::GRAM_BITS'(wide) : '0;
      item.gram_valid = full;
      item.last       = last_byte;
   end

   // Shift the window; drop it at the end of a file
   always_comb begin
      hist_in = wide[HIST_BITS-1:0];
      fill_in = full ? fill_ff : fill_ff + 1'b1;
      if (last_byte) begin
         hist_in = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
         fill_ff <= '0;
      end else if (accept) begin
         hist_ff <= hist_in;
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/btsb_back.sv -----
// Back end: seen-map read-modify-write with forwarding, distinct count,
// overflow flag, file epochs and the map clearing pass. Depends on btsb_pkg.
`default_nettype none

module btsb_back #(
   parameter int OUT_DEPTH = btsb_pkg::OUT_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [btsb_pkg::COUNT_BITS-1:0]     max_distinct,
   input  wire btsb_pkg::item_type                  head,
   input  wire logic                                head_empty,
   input  wire logic [$clog2(OUT_DEPTH+1)-1:0]      out_count,
   output logic                                     pop,
   output logic                                     ram_rd_en,
   output logic [btsb_pkg::ROW_ADDR_BITS-1:0]       ram_rd_addr,
   input  wire logic [btsb_pkg::ENTRY_BITS-1:0]     ram_rd_data,
   output logic                                     ram_wr_en,
   output logic [btsb_pkg::ROW_ADDR_BITS-1:0]       ram_wr_addr,
   output logic [btsb_pkg::ENTRY_BITS-1:0]          ram_wr_data,
   output logic                                     out_push,
   output btsb_pkg::result_type                     out_result,
   output btsb_pkg::back_status_type                status
);

   localparam int OCC_BITS = $clog2(OUT_DEPTH + 1) + 1;
   localparam logic [OCC_BITS-1:0] OCC_LIMIT = OCC_BITS'(OUT_DEPTH);
   localparam logic [btsb_pkg::ROW_ADDR_BITS-1:0] ROW_LAST =
      btsb_pkg::ROW_ADDR_BITS'(btsb_pkg::MAP_ROWS - 1);

   logic                                  clear_busy_ff;
   logic [btsb_pkg::ROW_ADDR_BITS-1:0]    clear_addr_ff;
   logic [btsb_pkg::EPOCH_BITS-1:0]       epoch_ff;
   logic                                  b_valid_ff;
   btsb_pkg::item_type                    b_item_ff;
   logic                                  fwd_valid_ff;
   logic [btsb_pkg::ROW_ADDR_BITS-1:0]    fwd_row_ff;
   logic [btsb_pkg::ROW_BITS-1:0]         fwd_data_ff;
   logic [btsb_pkg::EPOCH_BITS-1:0]       fwd_tag_ff;
   logic [btsb_pkg::COUNT_BITS-1:0]       count_ff;
   logic                                  ovf_ff;

   logic [OCC_BITS-1:0]                   occupancy;
   logic                                  wrap_hold;
   logic [btsb_pkg::ROW_ADDR_BITS-1:0]    b_row;
   logic [btsb_pkg::ROW_SEL_BITS-1:0]     b_sel;
   logic                                  use_fwd;
   logic [btsb_pkg::ROW_BITS-1:0]         cur_data;
   logic [btsb_pkg::EPOCH_BITS-1:0]       cur_tag;
   logic [btsb_pkg::ROW_BITS-1:0]         live;
   logic [btsb_pkg::ROW_BITS-1:0]         new_row;
   logic                                  fresh;
   logic                                  b_write;
   logic [btsb_pkg::COUNT_BITS-1:0]       count_next;
   logic                                  ovf_next;

   // Pop a request when the map is ready and the response queue has room
   assign occupancy = OCC_BITS'(out_count) + OCC_BITS'(b_valid_ff);
   assign wrap_hold = b_valid_ff && b_item_ff.last && (epoch_ff == btsb_pkg::EPOCH_MAX);
   assign pop = !head_empty && !clear_busy_ff && !wrap_hold && (occupancy < OCC_LIMIT);

   // Issue the map row read
   assign ram_rd_en   = pop;
   assign ram_rd_addr = head.gram[btsb_pkg::GRAM_BITS-1:btsb_pkg::ROW_SEL_BITS];

   // Merge read data with the last write and the current epoch
   always_comb begin
      b_row    = b_item_ff.gram[btsb_pkg::GRAM_BITS-1:btsb_pkg::ROW_SEL_BITS];
      b_sel    = b_item_ff.gram[btsb_pkg::ROW_SEL_BITS-1:0];
      use_fwd  = fwd_valid_ff && (fwd_row_ff == b_row);
      cur_data = use_fwd ? fwd_data_ff : ram_rd_data[btsb_pkg::ROW_BITS-1:0];
      cur_tag  = use_fwd ? fwd_tag_ff
                         : ram_rd_data[btsb_pkg::ENTRY_BITS-1:btsb_pkg::ROW_BITS];
      live     = (cur_tag == epoch_ff) ? cur_data : '0;
      new_row  = live | (btsb_pkg::ROW_BITS'(1) << b_sel);
      fresh    = b_item_ff.gram_valid && !live[b_sel];
      b_write  = b_valid_ff && fresh;
      count_next = count_ff + btsb_pkg::COUNT_BITS'(fresh);
      ovf_next   = ovf_ff || (b_item_ff.gram_valid && (count_next > max_distinct));
   end

   // Map write: clearing pass or set-bit update
   always_comb begin
      if (clear_busy_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = b_write;
         ram_wr_addr = b_row;
         ram_wr_data = {epoch_ff, new_row};
      end
   end

   // Result for the request in the map stage
   assign out_push = b_valid_ff;
   always_comb begin
      out_result.trigram       = b_item_ff.gram;
      out_result.trigram_valid = b_item_ff.gram_valid;
      out_result.is_new        = fresh;
      out_result.overflowed    = ovf_next;
      out_result.file_done     = b_item_ff.last;
   end

   always_comb begin
      status.clearing = clear_busy_ff;
      status.pop      = pop;
      status.busy     = b_valid_ff;
   end

   // Hold the request for its map stage
   always_ff @(posedge clock) begin
      if (pop) begin
         b_item_ff <= head;
      end
      if (b_write) begin
         fwd_row_ff  <= b_row;
         fwd_data_ff <= new_row;
         fwd_tag_ff  <= epoch_ff;
      end
   end

   // Control: stage valid, forwarding, counters, epochs and clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff    <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         epoch_ff      <= btsb_pkg::EPOCH_FIRST;
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         b_valid_ff <= pop;
         if (clear_busy_ff) begin
            fwd_valid_ff  <= 1'b0;
            clear_addr_ff <= clear_addr_ff + 1'b1;
            if (clear_addr_ff == ROW_LAST) begin
               clear_busy_ff <= 1'b0;
            end
         end else if (b_write) begin
            fwd_valid_ff <= 1'b1;
         end
         if (b_valid_ff) begin
            if (b_item_ff.last) begin
               count_ff <= '0;
               ovf_ff   <= 1'b0;
               if (count_next != '0) begin
                  if (epoch_ff == btsb_pkg::EPOCH_MAX) begin
                     epoch_ff      <= btsb_pkg::EPOCH_FIRST;
                     clear_busy_ff <= 1'b1;
                     clear_addr_ff <= '0;
                  end else begin
                     epoch_ff <= epoch_ff + 1'b1;
                  end
               end
            end else begin
               count_ff <= count_next;
               ovf_ff   <= ovf_next;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/byte_trigram_set_builder_unit.sv -----
// Top level of the byte trigram set builder: register port, front end, queues,
// back end and seen-map RAM. Depends on btsb_pkg and all btsb_* modules.
`default_nettype none

// The block takes one file byte per request and returns one response per
// request, in order: the current trigram (oldest byte high), whether the window
// was full, whether the trigram is new to this file, the sticky overflow flag
// and the end-of-file mark. It sustains one request per clock cycle when nothing
// stalls; a request passes through the request queue, the map stage and the
// response queue. The pace is set by the seen-map row read-modify-write, one
// row per cycle with forwarding of the previous write. The map is 2^18 rows of
// 64 bits, each tagged with a file epoch, so ending a file costs nothing. After
// reset, and after every 255th file that saw any trigram, a clearing pass
// rewrites every row of the map; requests are queued (up to QUEUE_DEPTH) and
// then stalled during the pass, and every file end in the last epoch keeps the
// next request out of the map stage. Register max_distinct lives at byte address 0.
module byte_trigram_set_builder_unit #(
   parameter int WINDOW_BYTES = btsb_pkg::WINDOW_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH  = btsb_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int OUT_DEPTH    = btsb_pkg::OUT_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [btsb_pkg::BYTE_BITS-1:0]      req_byte_value,
   input  wire logic                                req_last_byte,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [btsb_pkg::GRAM_BITS-1:0]           rsp_trigram,
   output logic                                     rsp_trigram_valid,
   output logic                                     rsp_is_new,
   output logic                                     rsp_overflowed,
   output logic                                     rsp_file_done,
   // register port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [btsb_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  wire logic [btsb_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic      [btsb_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                     pready
);

   localparam int ITEM_BITS   = $bits(btsb_pkg::item_type);
   localparam int RESULT_BITS = $bits(btsb_pkg::result_type);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int OCNT_BITS   = $clog2(OUT_DEPTH + 1);

   logic [btsb_pkg::COUNT_BITS-1:0]    max_distinct_ff;
   logic                               csr_write;
   logic                               csr_hit;

   logic                               req_accept;
   btsb_pkg::item_type                 front_item;
   btsb_pkg::item_type                 head_item;
   logic [ITEM_BITS-1:0]               head_bits;
   logic                               q_empty;
   logic                               q_full;
   logic [QCNT_BITS-1:0]               q_count;
   logic                               q_pop;

   logic                               ram_rd_en;
   logic [btsb_pkg::ROW_ADDR_BITS-1:0] ram_rd_addr;
   logic [btsb_pkg::ENTRY_BITS-1:0]    ram_rd_data;
   logic                               ram_wr_en;
   logic [btsb_pkg::ROW_ADDR_BITS-1:0] ram_wr_addr;
   logic [btsb_pkg::ENTRY_BITS-1:0]    ram_wr_data;

   logic                               out_push;
   btsb_pkg::result_type               out_result;
   btsb_pkg::result_type               rsp_result;
   logic [RESULT_BITS-1:0]             rsp_bits;
   logic                               out_empty;
   logic                               out_full;
   logic [OCNT_BITS-1:0]               out_count;
   logic                               rsp_accept;
   btsb_pkg::back_status_type          back_status;

   // Register port: one register, writes land on the access phase
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[btsb_pkg::CSR_ADDR_BITS-1:2] == btsb_pkg::CSR_INDEX_MAX_DISTINCT);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_distinct_ff <= btsb_pkg::LIMIT_RESET;
      end else if (csr_write && csr_hit) begin
         max_distinct_ff <= pwdata[btsb_pkg::COUNT_BITS-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata = btsb_pkg::CSR_DATA_BITS'(max_distinct_ff);
      end
   end

   // Request side
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   btsb_front #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .byte_value (req_byte_value),
      .last_byte  (req_last_byte),
      .item       (front_item)
   );

   btsb_fifo #(
      .WIDTH (ITEM_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_item),
      .pop       (q_pop),
      .pop_data  (head_bits),
      .empty     (q_empty),
      .full      (q_full),
      .count     (q_count)
   );

   assign head_item = btsb_pkg::item_type'(head_bits);

   btsb_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .max_distinct (max_distinct_ff),
      .head         (head_item),
      .head_empty   (q_empty),
      .out_count    (out_count),
      .pop          (q_pop),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .out_push     (out_push),
      .out_result   (out_result),
      .status       (back_status)
   );

   btsb_ram #(
      .WIDTH (btsb_pkg::ENTRY_BITS),
      .DEPTH (btsb_pkg::MAP_ROWS)
   ) u_seen_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Response side
   assign rsp_accept = rsp_valid && !rsp_stall;

   btsb_fifo #(
      .WIDTH (RESULT_BITS),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_result),
      .pop       (rsp_accept),
      .pop_data  (rsp_bits),
      .empty     (out_empty),
      .full      (out_full),
      .count     (out_count)
   );

   assign rsp_result        = btsb_pkg::result_type'(rsp_bits);
   assign rsp_valid         = !out_empty;
   assign rsp_trigram       = rsp_result.trigram;
   assign rsp_trigram_valid = rsp_result.trigram_valid;
   assign rsp_is_new        = rsp_result.is_new;
   assign rsp_overflowed    = rsp_result.overflowed;
   assign rsp_file_done     = rsp_result.file_done;

`ifndef SYNTHESIS
   // No request may enter the map stage while the clearing pass owns the RAM
   assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> !back_status.pop)
      else $error("request popped during map clearing pass");

   // A finished result always finds room in the response queue
   assert property (@(posedge clock) disable iff (reset)
      out_push |-> (!out_full || rsp_accept))
      else $error("response queue overrun");

   // Credit: queued plus in-flight results never exceed the queue depth
   assert property (@(posedge clock) disable iff (reset)
      ((OCNT_BITS + 1)'(out_count) + (OCNT_BITS + 1)'(back_status.busy))
         <= (OCNT_BITS + 1)'(OUT_DEPTH))
      else $error("response credit exceeded");

   // Request queue occupancy stays within its depth
   assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("request queue count out of range");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_byte_trigram_set_builder_unit.sv -----
// Self-checking testbench for byte_trigram_set_builder_unit.
// Streams files of bytes, predicts every response in a scoreboard class and
// checks it field by field. Depends on btsb_pkg and the block's RTL.
`default_nettype none

module tb_byte_trigram_set_builder_unit;

   // Register byte addresses: max_distinct is index 0, index 1 holds nothing
   localparam logic [btsb_pkg::CSR_ADDR_BITS-1:0] LIMIT_ADDR = 3'd0;
   localparam logic [btsb_pkg::CSR_ADDR_BITS-1:0] SPARE_ADDR = 3'd4;
   localparam logic [31:0] LIMIT_MASK    = 32'h01FF_FFFF;
   localparam logic [31:0] LIMIT_TOP     = 32'h0100_0000;
   localparam int          HISTORY_BITS  = 2 * btsb_pkg::BYTE_BITS;
   localparam int          FULL_FILL     = 2;
   // One stretch of requests between register writes
   localparam int          SEGMENT_LEN   = 160;
   localparam int          RANDOM_TARGET = 1450;
   // Enough trigram-bearing files to force the epoch wrap and its clearing pass
   localparam int          WRAP_FILES    = 260;
   localparam int          PRINT_CAP     = 200;
   // Room for the reset and wrap clearing passes plus slow traffic
   localparam int          CYCLE_LIMIT   = 2_000_000;

   logic                                  clock;
   logic                                  reset          = 1'b1;
   logic                                  req_valid      = 1'b0;
   logic                                  req_stall;
   logic [btsb_pkg::BYTE_BITS-1:0]        req_byte_value = '0;
   logic                                  req_last_byte  = 1'b0;
   logic                                  rsp_valid;
   logic                                  rsp_stall      = 1'b0;
   logic [btsb_pkg::GRAM_BITS-1:0]        rsp_trigram;
   logic                                  rsp_trigram_valid;
   logic                                  rsp_is_new;
   logic                                  rsp_overflowed;
   logic                                  rsp_file_done;
   logic                                  psel           = 1'b0;
   logic                                  penable        = 1'b0;
   logic                                  pwrite         = 1'b0;
   logic [btsb_pkg::CSR_ADDR_BITS-1:0]    paddr          = '0;
   logic [btsb_pkg::CSR_DATA_BITS-1:0]    pwdata         = '0;
   logic [btsb_pkg::CSR_DATA_BITS-1:0]    prdata;
   logic                                  pready;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned cycle_count   = 0;

   // Tracks the trigram set of the current file and the responses it must produce
   class gram_set_tracker;
      logic [btsb_pkg::COUNT_BITS-1:0] limit;
      logic [HISTORY_BITS-1:0]         history;
      int unsigned                     fill;
      bit                              seen_grams [bit [btsb_pkg::GRAM_BITS-1:0]];
      logic [btsb_pkg::COUNT_BITS-1:0] distinct;
      bit                              overflow;
      btsb_pkg::result_type            pending [$];
      int unsigned                     faults;

      function new();
         limit    = btsb_pkg::LIMIT_RESET;
         history  = '0;
         fill     = 0;
         distinct = '0;
         overflow = 1'b0;
         faults   = 0;
      endfunction

      function void report(string what, logic [31:0] want, logic [31:0] got);
         faults++;
         if (faults <= PRINT_CAP)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      endfunction

      // Advance the window by one accepted request and queue its response
      function void take_byte(logic [btsb_pkg::BYTE_BITS-1:0] value, logic last);
         btsb_pkg::result_type r;
         r = '0;
         if (fill >= FULL_FILL) begin
            r.trigram       = {history, value};
            r.trigram_valid = 1'b1;
         end
         history = {history[btsb_pkg::BYTE_BITS-1:0], value};
         if (fill < FULL_FILL)
            fill++;
         if (r.trigram_valid) begin
            if (!seen_grams.exists(r.trigram)) begin
               seen_grams[r.trigram] = 1'b1;
               distinct++;
               r.is_new = 1'b1;
            end
            if (distinct > limit)
               overflow = 1'b1;
         end
         r.overflowed = overflow;
         r.file_done  = last;
         pending = {pending, r};
         // File end drops the whole set
         if (last) begin
            seen_grams.delete();
            history  = '0;
            fill     = 0;
            distinct = '0;
            overflow = 1'b0;
         end
      endfunction

      // Compare one accepted response with the oldest queued one
      function void match_response(btsb_pkg::result_type got);
         btsb_pkg::result_type want;
         if (pending.size() == 0) begin
            report("unexpected response, trigram", 'x, got.trigram);
            return;
         end
         want = pending.pop_front();
         if (got.trigram !== want.trigram)
            report("trigram", want.trigram, got.trigram);
         if (got.trigram_valid !== want.trigram_valid)
            report("trigram_valid", want.trigram_valid, got.trigram_valid);
         if (got.is_new !== want.is_new)
            report("is_new", want.is_new, got.is_new);
         if (got.overflowed !== want.overflowed)
            report("overflowed", want.overflowed, got.overflowed);
         if (got.file_done !== want.file_done)
            report("file_done", want.file_done, got.file_done);
      endfunction
   endclass

   gram_set_tracker tracker = new();

   byte_trigram_set_builder_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_byte_value    (req_byte_value),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_trigram       (rsp_trigram),
      .rsp_trigram_valid (rsp_trigram_valid),
      .rsp_is_new        (rsp_is_new),
      .rsp_overflowed    (rsp_overflowed),
      .rsp_file_done     (rsp_file_done),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Check accepted responses, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.match_response(btsb_pkg::result_type'({rsp_trigram, rsp_trigram_valid,
                                                        rsp_is_new, rsp_overflowed,
                                                        rsp_file_done}));
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_byte_trigram_set_builder_unit: errors");
         $finish;
      end
   end

   // Offer one request, with random idle cycles first, and hold it until taken
   task automatic push_byte(input logic [btsb_pkg::BYTE_BITS-1:0] value, input logic last);
      while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_byte_value <= value;
      req_last_byte  <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      tracker.take_byte(value, last);
   endtask

   // Drop valid and wait until every queued response has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Run a setup and an access phase on the register port, then go idle
   task automatic csr_access(input logic write,
                             input logic [btsb_pkg::CSR_ADDR_BITS-1:0] addr,
                             input logic [31:0] data, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [btsb_pkg::CSR_ADDR_BITS-1:0] addr,
                            input logic [31:0] data);
      logic [31:0] unused;
      csr_access(1'b1, addr, data, unused);
      if (addr == LIMIT_ADDR)
         tracker.limit = data[btsb_pkg::COUNT_BITS-1:0];
   endtask

   task automatic check_limit_reg();
      logic [31:0] rdata;
      csr_access(1'b0, LIMIT_ADDR, '0, rdata);
      if (rdata !== (32'(tracker.limit) & LIMIT_MASK))
         tracker.report("max_distinct readback", 32'(tracker.limit), rdata);
   endtask

   task automatic run_directed();
      check_limit_reg();
      // Limit of one: second distinct trigram overflows, flag holds on a repeat
      write_reg(LIMIT_ADDR, 32'd1);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b1);
      // Short files give no trigram
      push_byte(8'hFF, 1'b1);
      push_byte(8'h80, 1'b0);
      push_byte(8'h01, 1'b1);
      // Same trigram in a fresh file is new again, no overflow at count one
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b1);
      settle();
      // Upper bits are masked away, leaving a limit of zero
      write_reg(LIMIT_ADDR, 32'hFE00_0000);
      check_limit_reg();
      push_byte(8'hAA, 1'b0);
      push_byte(8'h55, 1'b0);
      push_byte(8'hAA, 1'b1);
      settle();
      // Write to an unused index is dropped
      write_reg(SPARE_ADDR, 32'd7);
      check_limit_reg();
      write_reg(LIMIT_ADDR, LIMIT_TOP);
      check_limit_reg();
      push_byte(8'h7F, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'hFE, 1'b0);
      settle();
      // Lower the limit in the middle of a file
      write_reg(LIMIT_ADDR, 32'd1);
      push_byte(8'h02, 1'b0);
      push_byte(8'h7F, 1'b1);
      settle();
   endtask

   function automatic logic [31:0] pick_limit(int unsigned seg);
      case (seg % 9)
         0: return 32'd1;
         1: return 32'd2;
         2: return $urandom_range(24, 3);
         3: return LIMIT_TOP;
         4: return 32'(btsb_pkg::LIMIT_RESET);
         5: return $urandom;
         6: return 32'd0;
         7: return 32'hFFFF_FFFF;
         default: return $urandom_range(8, 1);
      endcase
   endfunction

   // Mostly short files so the epoch wraps, a few long ones for deep counts
   function automatic int unsigned pick_file_length();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8)
         return $urandom_range(2, 1);
      if (roll < 88)
         return $urandom_range(5, 3);
      if (roll < 98)
         return $urandom_range(14, 6);
      return $urandom_range(60, 15);
   endfunction

   task automatic run_random();
      int unsigned seg;
      int unsigned sent;
      int unsigned file_left;
      int unsigned gram_files;
      int unsigned alpha_base;
      int unsigned alpha_span;
      bit          narrow;
      logic [btsb_pkg::BYTE_BITS-1:0] value;
      seg        = 0;
      sent       = 0;
      file_left  = 0;
      gram_files = 0;
      alpha_base = 0;
      alpha_span = 1;
      narrow     = 1'b0;
      while (sent < RANDOM_TARGET || gram_files < WRAP_FILES || file_left != 0) begin
         settle();
         write_reg(LIMIT_ADDR, pick_limit(seg));
         check_limit_reg();
         // Rotate the idle pattern on both channels
         case (seg % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 69; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 69; end
            default: begin send_idle_pct = 21; stall_pct = 21; end
         endcase
         for (int unsigned n = 0; n < SEGMENT_LEN; n++) begin
            if (file_left == 0) begin
               if (sent >= RANDOM_TARGET && gram_files >= WRAP_FILES)
                  break;
               file_left  = pick_file_length();
               if (file_left >= 3)
                  gram_files++;
               // Narrow alphabets make repeated trigrams likely
               narrow     = 1'($urandom_range(1));
               alpha_base = $urandom_range(255);
               alpha_span = $urandom_range(3, 1);
            end
            if (narrow)
               value = 8'(alpha_base + $urandom_range(alpha_span));
            else
               value = 8'($urandom_range(255));
            file_left--;
            push_byte(value, file_left == 0);
            sent++;
         end
         seg++;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      settle();
      repeat (8) @(posedge clock);
      if (tracker.faults == 0 && tracker.pending.size() == 0)
         $display("tb_byte_trigram_set_builder_unit: clean");
      else
         $display("tb_byte_trigram_set_builder_unit: errors");
      $finish;
   end

endmodule

`default_nettype wire
